// ===== hdl/sgpc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgpc_pkg: shared definitions for the staggered grid point classifier
// Widths, register indexes, grid kinds, class codes and classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sgpc_pkg;

    localparam int FLAG_W  = 2;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 21;
    localparam int CLASS_W = 2;

    localparam int DEF_MAX_CELLS_PER_ROW = 1024;
    localparam int DEF_MAX_CELL_ROWS     = 1024;

    localparam logic [IDX_W-1:0] REG_GRID_KIND     = 2'd0;
    localparam logic [IDX_W-1:0] REG_CELLS_PER_ROW = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROWS_OF_CELLS = 2'd2;

    localparam logic [1:0] KIND_CELL = 2'd0;
    localparam logic [1:0] KIND_ROW  = 2'd1;
    localparam logic [1:0] KIND_COL  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [CLASS_W-1:0] CLS_INTERIOR = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_BOUNDARY = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_EXTERIOR = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_NONE     = 2'd3;

    localparam logic [FLAG_W-1:0] FLAG_INSIDE  = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_OUTSIDE = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_SPECIAL = 2'd2;

    localparam logic [CFG_W-1:0] RST_CELLS_PER_ROW = 11'd1024;
    localparam logic [CFG_W-1:0] RST_ROWS_OF_CELLS = 11'd1024;

    // cell-centred grid: class straight from the own cell flag
    function automatic logic [CLASS_W-1:0] class_of_cell(input logic [FLAG_W-1:0] flag);
        logic [CLASS_W-1:0] cls;
        case (flag)
            FLAG_INSIDE:  cls = CLS_INTERIOR;
            FLAG_OUTSIDE: cls = CLS_EXTERIOR;
            FLAG_SPECIAL: cls = CLS_BOUNDARY;
            default:      cls = CLS_NONE;
        endcase
        return cls;
    endfunction

    // staggered grid: class from the sum of the two neighbor flags
    function automatic logic [CLASS_W-1:0] class_of_pair(input logic [FLAG_W-1:0] lo,
                                                         input logic [FLAG_W-1:0] hi);
        logic [FLAG_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        if (sum > (FLAG_W+1)'(2))
            return CLS_NONE;
        return sum[CLASS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sgpc_line_buf.sv =====
// ----------------------------------------------------------------------------
// sgpc_line_buf: one-row flag line buffer
// Single write port, one registered read port with write-through bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpc_line_buf
    import sgpc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_CELLS_PER_ROW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [FLAG_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [FLAG_W-1:0] rdata
);

    logic [FLAG_W-1:0] mem [DEPTH];
    logic [FLAG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/staggered_grid_point_classifier_top.sv =====
// ----------------------------------------------------------------------------
// staggered_grid_point_classifier_top: staggered grid point classifier
// Raster scan of grid points, classification from neighbor mask flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cell_flag) takes one grid point per
//   request in row-major order. Output channel (out_valid/out_ready) gives
//   one result per point: class, linear index, list slot, running counts
//   and a last-point mark.
//   The result is registered in the cycle after the request is accepted.
//   Throughput: 1 point per cycle while out_ready is high; the result
//   register is the only stage; the line buffer read for the next column
//   is prefetched each cycle. When out_ready is low a held result blocks
//   in_ready; once taken, a new request is accepted in that same cycle.
//   Reset: registers return to cell-centred, 1024 x 1024; counters and
//   totals clear; no clearing pass, the line buffer holds garbage until
//   written. A config register write restarts the scan; write only
//   while idle. The scan also restarts after the last point.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_grid_point_classifier_top
    import sgpc_pkg::*;
#(
    parameter int MAX_CELLS_PER_ROW = DEF_MAX_CELLS_PER_ROW,
    parameter int MAX_CELL_ROWS     = DEF_MAX_CELL_ROWS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FLAG_W-1:0]  cell_flag,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CLASS_W-1:0]      point_class,
    output logic [CNT_W-1:0]        point_index,
    output logic                    outer_side,
    output logic [CNT_W-1:0]        list_slot,
    output logic [CNT_W-1:0]        interior_count,
    output logic [CNT_W-1:0]        boundary_count,
    output logic [CNT_W-1:0]        exterior_count,
    output logic                    last_point
);

    localparam int COL_W = $clog2(MAX_CELLS_PER_ROW + 2);
    localparam int ROW_W = $clog2(MAX_CELL_ROWS + 2);
    localparam int CSZ_W = (COL_W > CFG_W) ? COL_W : CFG_W;
    localparam int RSZ_W = (ROW_W > CFG_W) ? ROW_W : CFG_W;
    localparam int AW    = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;

    // config registers
    logic [1:0]        grid_kind_reg;
    logic [CFG_W-1:0]  cells_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic              restart;

    // scan state
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  pt_reg, pt_next;
    logic [CNT_W-1:0]  int_reg, int_next;
    logic [CNT_W-1:0]  bnd_reg, bnd_next;
    logic [CNT_W-1:0]  ext_reg, ext_next;
    logic [FLAG_W-1:0] prev_flag_reg;

    // result register
    logic               out_valid_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               outer_reg;
    logic [CNT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]   int_out_reg;
    logic [CNT_W-1:0]   bnd_out_reg;
    logic [CNT_W-1:0]   ext_out_reg;
    logic               last_reg;

    // datapath
    logic               in_accept;
    logic [1:0]         kind;
    logic [CSZ_W-1:0]   cells_c, pcol, col_ext;
    logic [RSZ_W-1:0]   rows_c, prow, row_ext;
    logic               row_in, col_in, col_last, row_last, last;
    logic [FLAG_W-1:0]  lo, hi, above_flag;
    logic [CLASS_W-1:0] cls;
    logic               outer;
    logic [CNT_W-1:0]   slot, int_inc, bnd_inc, ext_inc;
    logic               buf_we;

    assign restart   = cfg_we && ((cfg_index == REG_GRID_KIND) ||
                                  (cfg_index == REG_CELLS_PER_ROW) ||
                                  (cfg_index == REG_ROWS_OF_CELLS));
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        kind = (grid_kind_reg == KIND_RSVD) ? KIND_CELL : grid_kind_reg;

        if (cells_reg == '0)
            cells_c = CSZ_W'(1);
        else if (CSZ_W'(cells_reg) > CSZ_W'(MAX_CELLS_PER_ROW))
            cells_c = CSZ_W'(MAX_CELLS_PER_ROW);
        else
            cells_c = CSZ_W'(cells_reg);

        if (rows_reg == '0)
            rows_c = RSZ_W'(1);
        else if (RSZ_W'(rows_reg) > RSZ_W'(MAX_CELL_ROWS))
            rows_c = RSZ_W'(MAX_CELL_ROWS);
        else
            rows_c = RSZ_W'(rows_reg);

        pcol    = cells_c + CSZ_W'(kind == KIND_COL);
        prow    = rows_c + RSZ_W'(kind == KIND_ROW);
        col_ext = CSZ_W'(col_reg);
        row_ext = RSZ_W'(row_reg);

        row_in   = row_ext < rows_c;
        col_in   = col_ext < cells_c;
        col_last = (col_ext + CSZ_W'(1)) >= pcol;
        row_last = (row_ext + RSZ_W'(1)) >= prow;
        last     = row_last && col_last;

        lo = FLAG_OUTSIDE;
        hi = FLAG_OUTSIDE;
        case (kind)
            KIND_ROW:
            begin
                lo = (row_reg != '0) ? above_flag : FLAG_OUTSIDE;
                hi = row_in ? cell_flag : FLAG_OUTSIDE;
            end
            KIND_COL:
            begin
                lo = (col_reg != '0) ? prev_flag_reg : FLAG_OUTSIDE;
                hi = col_in ? cell_flag : FLAG_OUTSIDE;
            end
            default:
            begin
                lo = FLAG_OUTSIDE;
                hi = FLAG_OUTSIDE;
            end
        endcase

        if (kind == KIND_CELL)
            cls = class_of_cell(cell_flag);
        else
            cls = class_of_pair(lo, hi);
        outer = (kind != KIND_CELL) && (cls == CLS_BOUNDARY) && (lo == FLAG_OUTSIDE);

        int_inc = int_reg;
        bnd_inc = bnd_reg;
        ext_inc = ext_reg;
        slot    = '0;
        case (cls)
            CLS_INTERIOR:
            begin
                slot    = int_reg;
                int_inc = int_reg + CNT_W'(1);
            end
            CLS_BOUNDARY:
            begin
                slot    = bnd_reg;
                bnd_inc = bnd_reg + CNT_W'(1);
            end
            CLS_EXTERIOR:
            begin
                slot    = ext_reg;
                ext_inc = ext_reg + CNT_W'(1);
            end
            default:
            begin
                slot = '0;
            end
        endcase

        buf_we = in_accept && row_in && col_in;

        col_next = col_reg;
        row_next = row_reg;
        pt_next  = pt_reg;
        int_next = int_reg;
        bnd_next = bnd_reg;
        ext_next = ext_reg;
        if (restart || (in_accept && last))
        begin
            col_next = '0;
            row_next = '0;
            pt_next  = '0;
            int_next = '0;
            bnd_next = '0;
            ext_next = '0;
        end
        else if (in_accept)
        begin
            pt_next  = pt_reg + CNT_W'(1);
            int_next = int_inc;
            bnd_next = bnd_inc;
            ext_next = ext_inc;
            if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    sgpc_line_buf #(
        .DEPTH (MAX_CELLS_PER_ROW),
        .AW    (AW)
    ) u_line_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (col_reg[AW-1:0]),
        .wdata (cell_flag),
        .raddr (col_next[AW-1:0]),
        .rdata (above_flag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_kind_reg <= KIND_CELL;
            cells_reg     <= RST_CELLS_PER_ROW;
            rows_reg      <= RST_ROWS_OF_CELLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_KIND:     grid_kind_reg <= cfg_wdata[1:0];
                REG_CELLS_PER_ROW: cells_reg     <= cfg_wdata;
                REG_ROWS_OF_CELLS: rows_reg      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            pt_reg        <= '0;
            int_reg       <= '0;
            bnd_reg       <= '0;
            ext_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pt_reg  <= pt_next;
            int_reg <= int_next;
            bnd_reg <= bnd_next;
            ext_reg <= ext_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            prev_flag_reg <= cell_flag;
        end
        if (in_accept)
        begin
            cls_reg     <= cls;
            idx_reg     <= pt_reg;
            outer_reg   <= outer;
            slot_reg    <= slot;
            int_out_reg <= int_inc;
            bnd_out_reg <= bnd_inc;
            ext_out_reg <= ext_inc;
            last_reg    <= last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign point_class    = cls_reg;
    assign point_index    = idx_reg;
    assign outer_side     = outer_reg;
    assign list_slot      = slot_reg;
    assign interior_count = int_out_reg;
    assign boundary_count = bnd_out_reg;
    assign exterior_count = ext_out_reg;
    assign last_point     = last_reg;

endmodule

`default_nettype wire
